[rtl/pab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pab_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int NPIX_W     = $clog2(DEPTH + 1);
  localparam int DIM_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_STEPS  = 33;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOR  = 2'd1;
  localparam logic [1:0] STAT_DONE = 2'd2;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_NORM  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] pixel_index;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] red_out;
    logic [31:0] green_out;
    logic [31:0] blue_out;
    logic [15:0] count_out;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [15:0] count;
  } pix_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_ACC_RD,
    S_ACC_WR,
    S_RD_RD,
    S_NRM_RD,
    S_NRM_CHK,
    S_NRM_DIV,
    S_NRM_WR,
    S_CLR,
    S_DONE
  } state_t;

  typedef enum logic {
    ADDR_ITEM,
    ADDR_SWEEP
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_ACC,
    WR_NORM,
    WR_ZERO
  } wr_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      idx_clr;
    logic      idx_inc;
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    wr_sel_t   wr_sel;
    logic      div_start;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic cnt_nonzero;
    logic div_done;
    logic last_used;
    logic last_all;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

[rtl/pab_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module pab_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] num,
  input  wire logic [15:0] den,
  output logic [31:0]      quo,
  output logic             done
);
  import pab_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [15:0]       rem;
  logic [32:0]       q;
  logic [15:0]       dreg;
  logic [16:0]       rem_sh;
  logic              ge;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, q[32]};
    ge     = (rem_sh >= {1'b0, dreg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? 16'(rem_sh - {1'b0, dreg}) : rem_sh[15:0];
      q   <= {q[31:0], ge};
    end
  end

  assign quo  = q[31:0];
  assign done = !busy;

endmodule
`default_nettype wire

[rtl/pab_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module pab_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire pab_pkg::stat_t stat,
  output pab_pkg::cmd_t       cmd
);
  import pab_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  // sequence one item at a time through the store
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addr_sel = ADDR_ITEM;
    cmd.wr_sel   = WR_ZERO;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_INIT_CLR: begin
        cmd.addr_sel = ADDR_SWEEP;
        cmd.mem_wr   = 1'b1;
        cmd.wr_sel   = WR_ZERO;
        if (stat.last_all) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next    = S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        // dispatch on the captured operation
        unique case (stat.op)
          OP_ACC: begin
            if (stat.in_range) begin
              cmd.mem_rd = 1'b1;
              state_next = S_ACC_WR;
            end else begin
              state_next = S_DONE;
            end
          end
          OP_READ: begin
            state_next = S_RD_RD;
          end
          OP_NORM: begin
            state_next = S_NRM_RD;
          end
          default: begin
            state_next = S_CLR;
          end
        endcase
      end
      S_ACC_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WR_ACC;
        state_next = S_DONE;
      end
      S_RD_RD: begin
        cmd.mem_rd = stat.in_range;
        state_next = S_DONE;
      end
      S_NRM_RD: begin
        cmd.addr_sel = ADDR_SWEEP;
        cmd.mem_rd   = 1'b1;
        state_next   = S_NRM_CHK;
      end
      S_NRM_CHK: begin
        if (stat.cnt_nonzero) begin
          cmd.div_start = 1'b1;
          state_next    = S_NRM_DIV;
        end else begin
          state_next = S_NRM_WR;
        end
      end
      S_NRM_DIV: begin
        if (stat.div_done) begin
          state_next = S_NRM_WR;
        end
      end
      S_NRM_WR: begin
        cmd.addr_sel = ADDR_SWEEP;
        cmd.mem_wr   = 1'b1;
        cmd.wr_sel   = WR_NORM;
        if (stat.last_used) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_NRM_RD;
        end
      end
      S_CLR: begin
        cmd.addr_sel = ADDR_SWEEP;
        cmd.mem_wr   = 1'b1;
        cmd.wr_sel   = WR_ZERO;
        if (stat.last_all) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/pab_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module pab_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pab_pkg::in_item_t        in_data,
  input  wire logic                     cfg_we,
  input  wire logic [pab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pab_pkg::DIM_W-1:0]     cfg_data,
  input  wire pab_pkg::cmd_t            cmd,
  output pab_pkg::stat_t                stat,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output pab_pkg::out_item_t            out_data
);
  import pab_pkg::*;

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [DIM_W-1:0]  w_use;
  logic [DIM_W-1:0]  h_use;
  logic [NPIX_W-1:0] npix;

  op_t               item_op;
  logic              item_in_range;
  logic [ADDR_W-1:0] item_addr;
  logic [15:0]       item_red;
  logic [15:0]       item_green;
  logic [15:0]       item_blue;
  logic              load_in_range;
  logic [ADDR_W-1:0] load_addr;
  logic [16:0]       row_base;

  logic [ADDR_W-1:0] sweep;
  logic [ADDR_W-1:0] addr;

  pix_t              mem [DEPTH];
  pix_t              mem_q;
  pix_t              wr_data;
  pix_t              acc_pix;
  logic [32:0]       sum_r;
  logic [32:0]       sum_g;
  logic [32:0]       sum_b;

  logic [31:0]       quo_r;
  logic [31:0]       quo_g;
  logic [31:0]       quo_b;
  logic              done_r;
  logic              done_g;
  logic              done_b;
  logic [32:0]       half;

  out_item_t         res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(MAX_WIDTH);
      frame_height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) begin
        frame_width <= cfg_data;
      end
      if (cfg_index == CFG_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  // clamp the frame size and count the pixels in use
  always_comb begin
    if (frame_width == '0) begin
      w_use = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      w_use = DIM_W'(MAX_WIDTH);
    end else begin
      w_use = frame_width;
    end
    if (frame_height == '0) begin
      h_use = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      h_use = DIM_W'(MAX_HEIGHT);
    end else begin
      h_use = frame_height;
    end
    npix = NPIX_W'(w_use * h_use);
  end

  // resolve the item's address and range check at load
  always_comb begin
    row_base = 17'(in_data.pos_y * w_use);
    if (in_data.operation == OP_READ) begin
      load_in_range = ({1'b0, in_data.pos_x} < w_use) && ({1'b0, in_data.pos_y} < h_use);
      load_addr     = ADDR_W'(row_base + 17'(in_data.pos_x));
    end else begin
      load_in_range = (NPIX_W'(in_data.pixel_index) < npix);
      load_addr     = ADDR_W'(in_data.pixel_index);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op       <= in_data.operation;
      item_in_range <= load_in_range;
      item_addr     <= load_addr;
      item_red      <= in_data.red_in;
      item_green    <= in_data.green_in;
      item_blue     <= in_data.blue_in;
    end
  end

  // sweep index for clear and normalize passes
  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clr) begin
      sweep <= '0;
    end else if (cmd.idx_inc) begin
      sweep <= sweep + 1'b1;
    end
  end

  assign addr = (cmd.addr_sel == ADDR_SWEEP) ? sweep : item_addr;

  // saturating accumulate
  always_comb begin
    sum_r = {1'b0, mem_q.red}   + 33'(item_red);
    sum_g = {1'b0, mem_q.green} + 33'(item_green);
    sum_b = {1'b0, mem_q.blue}  + 33'(item_blue);
    acc_pix.red   = sum_r[32] ? '1 : sum_r[31:0];
    acc_pix.green = sum_g[32] ? '1 : sum_g[31:0];
    acc_pix.blue  = sum_b[32] ? '1 : sum_b[31:0];
    acc_pix.count = (mem_q.count == '1) ? mem_q.count : mem_q.count + 1'b1;
  end

  always_comb begin
    wr_data = '0;
    unique case (cmd.wr_sel)
      WR_ACC: begin
        wr_data = acc_pix;
      end
      WR_NORM: begin
        if (mem_q.count != '0) begin
          wr_data.red   = quo_r;
          wr_data.green = quo_g;
          wr_data.blue  = quo_b;
        end else begin
          wr_data.red   = mem_q.red;
          wr_data.green = mem_q.green;
          wr_data.blue  = mem_q.blue;
        end
        wr_data.count = 16'd1;
      end
      default: begin
        wr_data = '0;
      end
    endcase
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[addr];
    end
  end

  // rounded averages, one quotient bit per cycle per color
  assign half = 33'(mem_q.count[15:1]);

  pab_div u_div_r (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({1'b0, mem_q.red} + half),
    .den   (mem_q.count),
    .quo   (quo_r),
    .done  (done_r)
  );

  pab_div u_div_g (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({1'b0, mem_q.green} + half),
    .den   (mem_q.count),
    .quo   (quo_g),
    .done  (done_g)
  );

  pab_div u_div_b (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({1'b0, mem_q.blue} + half),
    .den   (mem_q.count),
    .quo   (quo_b),
    .done  (done_b)
  );

  // build the result item
  always_comb begin
    res = '0;
    unique case (item_op)
      OP_ACC: begin
        res.status = item_in_range ? STAT_OK : STAT_OOR;
      end
      OP_READ: begin
        if (item_in_range) begin
          res.red_out   = mem_q.red;
          res.green_out = mem_q.green;
          res.blue_out  = mem_q.blue;
          res.count_out = mem_q.count;
          res.status    = STAT_OK;
        end else begin
          res.count_out = 16'd1;
          res.status    = STAT_OOR;
        end
      end
      default: begin
        res.status = STAT_DONE;
      end
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data <= res;
    end
  end

  always_comb begin
    stat.op          = item_op;
    stat.in_range    = item_in_range;
    stat.cnt_nonzero = (mem_q.count != '0);
    stat.div_done    = done_r && done_g && done_b;
    stat.last_used   = ({1'b0, sweep} == NPIX_W'(npix - 1'b1));
    stat.last_all    = (sweep == '1);
    stat.out_free    = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

[rtl/pixel_accumulation_buffer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pixel accumulation buffer: a 256 x 256 store of Q24.8 RGB sums and 16-bit
// sample counts in one single-port memory, with one item handled at a time and
// one result item per input item. After reset the store is swept to zero before
// the first item is taken. Accumulate reads the pixel and then does a saturating
// write before its result is loaded; read does one memory read, and clear sweeps
// the whole store. Normalize walks the pixels in use through the memory port and
// three bit-serial dividers: a pixel with a zero count is read and written back,
// one with a nonzero count also runs the dividers. The result waits in an output
// register, and the next item is taken once the result is loaded there.
module pixel_accumulation_buffer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pab_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pab_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [pab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pab_pkg::DIM_W-1:0]     cfg_data
);
  import pab_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pab_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/pab_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module pab_port_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire pab_pkg::out_item_t out_data
);
  import pab_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: stall right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // frame operations report zero sums and count
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STAT_DONE |->
      out_data.red_out == '0 && out_data.green_out == '0 &&
      out_data.blue_out == '0 && out_data.count_out == '0)
    else $error("frame result not zero");

  // out of range results carry no sums
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STAT_OOR |->
      out_data.red_out == '0 && out_data.green_out == '0 && out_data.blue_out == '0)
    else $error("out of range result has sums");

endmodule

bind pixel_accumulation_buffer_top pab_port_checker u_pab_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[verif/pab_checker.sv]
`timescale 1ns / 1ps
module pab_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  pab_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  pab_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [pab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pab_pkg::DIM_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import pab_pkg::*;

  // shadow copy of the pixel store and frame size
  logic [31:0] red_acc   [DEPTH];
  logic [31:0] green_acc [DEPTH];
  logic [31:0] blue_acc  [DEPTH];
  logic [15:0] hits      [DEPTH];
  logic [DIM_W-1:0] width_reg, height_reg;
  out_item_t   expected_q [$];

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] round_avg(logic [31:0] s, logic [15:0] c);
    logic [63:0] n;
    n = {32'd0, s} + (c >> 1);
    return 32'(n / c);
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < DEPTH; i++) begin
      red_acc[i] = '0; green_acc[i] = '0; blue_acc[i] = '0; hits[i] = '0;
    end
  endfunction

  // apply one item to the shadow store and return its result
  function automatic out_item_t pixel_result(in_item_t it);
    out_item_t r;
    int w, h, npix, a;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    npix = w * h;
    r = '0;
    case (it.operation)
      OP_ACC: begin
        a = it.pixel_index;
        if (a < npix) begin
          red_acc[a]   = sat_add(red_acc[a], it.red_in);
          green_acc[a] = sat_add(green_acc[a], it.green_in);
          blue_acc[a]  = sat_add(blue_acc[a], it.blue_in);
          if (hits[a] != 16'hFFFF) hits[a] = hits[a] + 1'b1;
          r.status = STAT_OK;
        end else begin
          r.status = STAT_OOR;
        end
      end
      OP_READ: begin
        if (it.pos_x < w && it.pos_y < h) begin
          a = it.pos_y * w + it.pos_x;
          r.red_out = red_acc[a];
          r.green_out = green_acc[a];
          r.blue_out = blue_acc[a];
          r.count_out = hits[a];
          r.status = STAT_OK;
        end else begin
          r.count_out = 16'd1;
          r.status = STAT_OOR;
        end
      end
      OP_NORM: begin
        for (int i = 0; i < npix; i++) begin
          if (hits[i] != 0) begin
            red_acc[i]   = round_avg(red_acc[i], hits[i]);
            green_acc[i] = round_avg(green_acc[i], hits[i]);
            blue_acc[i]  = round_avg(blue_acc[i], hits[i]);
          end
          hits[i] = 16'd1;
        end
        r.status = STAT_DONE;
      end
      default: begin
        wipe_store();
        r.status = STAT_DONE;
      end
    endcase
    return r;
  endfunction

  // track config, predict accepted items, compare accepted results
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      width_reg = 9'd256;
      height_reg = 9'd256;
      wipe_store();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_HEIGHT) height_reg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (want.red_out !== out_data.red_out ||
              want.green_out !== out_data.green_out ||
              want.blue_out !== out_data.blue_out ||
              want.count_out !== out_data.count_out ||
              want.status !== out_data.status) begin
            $display("%0t: mismatch expected r=%h g=%h b=%h c=%h s=%0d", $time,
                     want.red_out, want.green_out, want.blue_out, want.count_out,
                     want.status);
            $display("%0t:          actual   r=%h g=%h b=%h c=%h s=%0d", $time,
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.count_out, out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(pixel_result(in_data));
    end
    pending = expected_q.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import pab_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  bit                   idle_on = 1'b1;
  bit                   hold_req = 1'b0;
  int                   cur_w = 256, cur_h = 256;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_accumulation_buffer_top DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  pab_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // end the run at the cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random stall bursts and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one item and hold it until taken
  task automatic send(op_t op, logic [15:0] idx, logic [7:0] x, logic [7:0] y,
                      logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_item_t it;
    it.operation = op; it.pixel_index = idx; it.pos_x = x; it.pos_y = y;
    it.red_in = r; it.green_in = g; it.blue_in = b;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_WIDTH; cfg_data <= w[DIM_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= h[DIM_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_w = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    cur_h = (h == 0) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
  endtask

  // random item: mostly accumulate into the frame, reads, rare normalize
  task automatic random_item(bit allow_norm);
    int sel, npix;
    logic [15:0] idx;
    logic [7:0] x, y;
    npix = cur_w * cur_h;
    sel = $urandom_range(0, 99);
    idx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, npix - 1));
    x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, cur_w - 1));
    y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, cur_h - 1));
    if (allow_norm && sel < 2)
      send(OP_NORM, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom));
    else if (sel < 62)
      send(OP_ACC, idx, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
    else
      send(OP_READ, 16'($urandom), x, y, 16'($urandom), 16'($urandom),
           16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full frame: corners and one normalize over a sparse store
    send(OP_ACC, 16'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_ACC, 16'd0, 8'd0, 8'd0, 16'h0001, 16'h8000, 16'h0000);
    send(OP_ACC, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'hAAAA);
    send(OP_ACC, 16'hFFFF, 8'hFF, 8'hFF, 16'h5555, 16'hFFFF, 16'h5555);
    send(OP_ACC, 16'h1234, 8'hFF, 8'hFF, 16'h0003, 16'h0005, 16'h0007);
    send(OP_READ, 16'hFFFF, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_READ, 16'd0, 8'hFF, 8'hFF, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'hFF, 8'h00, 16'd0, 16'd0, 16'd0);
    send(OP_NORM, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'hFF, 8'hFF, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'h34, 8'h12, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'd7, 8'd7, 16'd0, 16'd0, 16'd0);

    // a zero width and height clamp to one pixel; out-of-range access on both axes
    set_frame(0, 0);
    send(OP_ACC, 16'd1, 8'd0, 8'd0, 16'd9, 16'd9, 16'd9);
    send(OP_READ, 16'd0, 8'd1, 8'd0, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'd0, 8'd1, 16'd0, 16'd0, 16'd0);
    send(OP_CLEAR, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    // hammer the single pixel back to back with full-scale samples
    idle_on = 1'b0;
    for (int i = 0; i < 16; i++)
      send(OP_ACC, 16'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_READ, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send(OP_NORM, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    send(OP_READ, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    idle_on = 1'b1;

    // random phases over a spread of frame sizes, oversized values included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_frame(511, 3);
        1: set_frame(5, 7);
        2: set_frame(1, 256);
        3: set_frame(3, 511);
        4: set_frame($urandom_range(1, 20), $urandom_range(1, 20));
        default: set_frame(16, 16);
      endcase
      if (ph == 2) send(OP_CLEAR, 16'($urandom), 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) idle_on = 1'b0;
      for (int n = 0; n < 265; n++) random_item(1'b1);
    end
    send(OP_NORM, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    for (int n = 0; n < 20; n++) random_item(1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
